// ----- src/ascii_pgm_stream_parser_core_defines.svh -----
// Assertion macros used by the checker file of the PGM parser.
`ifndef ASCII_PGM_STREAM_PARSER_CORE_DEFINES_SVH
`define ASCII_PGM_STREAM_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, idle while in reset.
`define PGMP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, idle while in reset.
`define PGMP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/pgmp_pkg.sv -----
`timescale 1ns / 1ps

package pgmp_pkg;

    localparam int VALUE_BITS_DEFAULT = 16;
    localparam int THRESH_W           = 16;
    localparam int PIX_CNT_W          = 32;
    localparam int KIND_W             = 3;
    localparam int FIFO_DEPTH         = 4;   // power of two, at least 2
    localparam int APB_DATA_W         = 32;
    localparam int APB_ADDR_W         = 3;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd128;

    // Register indexes, taken from paddr[2].
    localparam logic REG_BINARIZE  = 1'b0;
    localparam logic REG_THRESHOLD = 1'b1;

    localparam logic [7:0] CHAR_P     = 8'h50;
    localparam logic [7:0] CHAR_2     = 8'h32;
    localparam logic [7:0] CHAR_HASH  = 8'h23;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;

    typedef enum logic [KIND_W-1:0] {
        KIND_WIDTH     = 3'd0,
        KIND_HEIGHT    = 3'd1,
        KIND_MAXVAL    = 3'd2,
        KIND_PIXEL     = 3'd3,
        KIND_BAD_MAGIC = 3'd4,
        KIND_EARLY_END = 3'd5,
        KIND_EMPTY     = 3'd6
    } pgmp_kind_t;

    typedef enum logic [5:0] {
        PH_MAGIC  = 6'b000001,
        PH_WIDTH  = 6'b000010,
        PH_HEIGHT = 6'b000100,
        PH_MAXVAL = 6'b001000,
        PH_PIXELS = 6'b010000,
        PH_DONE   = 6'b100000
    } pgmp_phase_t;

    typedef struct packed {
        logic                binarize_enable;
        logic [THRESH_W-1:0] threshold;
    } pgmp_cfg_t;

endpackage

// ----- src/pgmp_cfg_regs.sv -----
`timescale 1ns / 1ps

module pgmp_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pgmp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [pgmp_pkg::APB_DATA_W-1:0] pwdata,
    output logic [pgmp_pkg::APB_DATA_W-1:0] prdata,
    output pgmp_pkg::pgmp_cfg_t             cfg
);
    import pgmp_pkg::*;

    logic                binarize_reg;
    logic [THRESH_W-1:0] threshold_reg;
    logic                wr_en;

    // pready is tied high, so the access phase always completes.
    assign wr_en = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            binarize_reg  <= 1'b0;
            threshold_reg <= THRESH_RESET;
        end else if (wr_en) begin
            case (paddr[2])
                REG_BINARIZE:  binarize_reg  <= pwdata[0];
                REG_THRESHOLD: threshold_reg <= pwdata[THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_BINARIZE:  prdata = APB_DATA_W'(binarize_reg);
            REG_THRESHOLD: prdata = APB_DATA_W'(threshold_reg);
            default:       prdata = '0;
        endcase
    end

    assign cfg.binarize_enable = binarize_reg;
    assign cfg.threshold       = threshold_reg;

endmodule

// ----- src/pgmp_parser.sv -----
`timescale 1ns / 1ps

module pgmp_parser #(
    parameter int VALUE_BITS = pgmp_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       in_valid,
    input  logic [7:0]                                 in_byte,
    input  logic                                       in_eos,
    input  pgmp_pkg::pgmp_cfg_t                        cfg,
    output logic [1:0]                                 res_count,
    output logic [VALUE_BITS+pgmp_pkg::KIND_W:0]       res_word0,
    output logic [VALUE_BITS+pgmp_pkg::KIND_W:0]       res_word1
);
    import pgmp_pkg::*;

    localparam int ACC_W   = VALUE_BITS + 4;
    localparam int ENTRY_W = VALUE_BITS + KIND_W + 1;
    localparam int CMP_W   = (VALUE_BITS > THRESH_W) ? VALUE_BITS : THRESH_W;

    pgmp_phase_t            phase_reg, phase_next;
    logic                   comment_reg, comment_next;
    logic                   token_reg, token_next;
    logic                   digits_ok_reg, digits_ok_next;
    logic [VALUE_BITS-1:0]  acc_reg, acc_next;
    logic [1:0]             magic_prog_reg, magic_prog_next;
    logic                   magic_ok_reg, magic_ok_next;
    logic [VALUE_BITS-1:0]  width_reg, width_next;
    logic [PIX_CNT_W-1:0]   remain_reg, remain_next;

    logic [2*VALUE_BITS-1:0] area;
    logic [63:0]             area_wide;
    logic [PIX_CNT_W-1:0]    area_sat;
    logic [PIX_CNT_W-1:0]    remain_dec;
    logic [ACC_W-1:0]        acc_wide;
    logic [ACC_W-1:0]        acc_x10;
    logic [VALUE_BITS-1:0]   pixel_val;

    // Word layout: {last_pixel, kind, value}.
    function automatic logic [ENTRY_W-1:0] make_word(pgmp_kind_t k,
                                                     logic [VALUE_BITS-1:0] v,
                                                     logic last);
        make_word = {last, k, v};
    endfunction

    // Pixel count from width and height, clamped to the 32-bit counter.
    assign area      = width_reg * acc_reg;
    assign area_wide = 64'(area);
    assign area_sat  = (|area_wide[63:PIX_CNT_W]) ? '1 : area_wide[PIX_CNT_W-1:0];
    assign remain_dec = remain_reg - PIX_CNT_W'(1);

    always_comb begin
        if (cfg.binarize_enable) begin
            pixel_val = (CMP_W'(acc_reg) < CMP_W'(cfg.threshold)) ? '0 : VALUE_BITS'(1);
        end else begin
            pixel_val = acc_reg;
        end
    end

    always_comb begin
        logic             do_finish;
        logic             tok_dv;
        logic [VALUE_BITS-1:0] tok_acc;
        logic [1:0]       tok_prog;
        logic             tok_ok;

        phase_next      = phase_reg;
        comment_next    = comment_reg;
        token_next      = token_reg;
        digits_ok_next  = digits_ok_reg;
        acc_next        = acc_reg;
        magic_prog_next = magic_prog_reg;
        magic_ok_next   = magic_ok_reg;
        width_next      = width_reg;
        remain_next     = remain_reg;
        res_count       = 2'd0;
        res_word0       = '0;
        res_word1       = '0;
        do_finish       = 1'b0;
        acc_wide        = '0;
        acc_x10         = '0;

        // A fresh token starts from a clean accumulator and magic matcher.
        tok_dv   = token_reg ? digits_ok_reg  : 1'b1;
        tok_acc  = token_reg ? acc_reg        : '0;
        tok_prog = token_reg ? magic_prog_reg : 2'd0;
        tok_ok   = token_reg ? magic_ok_reg   : 1'b1;

        if (in_valid && (phase_reg != PH_DONE)) begin
            if (in_eos) begin
                do_finish = token_reg;
            end else if (comment_reg) begin
                if (in_byte == CHAR_LF) begin
                    comment_next = 1'b0;
                end
            end else if (in_byte == CHAR_HASH) begin
                do_finish    = token_reg;
                comment_next = 1'b1;
            end else if (in_byte inside {CHAR_SPACE, CHAR_TAB, CHAR_LF}) begin
                do_finish = token_reg;
            end else begin
                token_next = 1'b1;
                digits_ok_next = tok_dv;
                acc_next = tok_acc;
                if (tok_dv) begin
                    if (in_byte inside {[CHAR_0:CHAR_9]}) begin
                        acc_wide = ACC_W'(tok_acc);
                        acc_x10  = (acc_wide << 3) + (acc_wide << 1)
                                 + ACC_W'(in_byte[3:0]);
                        acc_next = (|acc_x10[ACC_W-1:VALUE_BITS]) ? '1
                                 : acc_x10[VALUE_BITS-1:0];
                    end else begin
                        digits_ok_next = 1'b0;
                    end
                end
                magic_prog_next = tok_prog;
                magic_ok_next   = tok_ok;
                if (tok_ok) begin
                    if (tok_prog == 2'd0 && in_byte == CHAR_P) begin
                        magic_prog_next = 2'd1;
                    end else if (tok_prog == 2'd1 && in_byte == CHAR_2) begin
                        magic_prog_next = 2'd2;
                    end else begin
                        magic_ok_next = 1'b0;
                    end
                end
            end
        end

        if (do_finish) begin
            token_next = 1'b0;
            case (phase_reg)
                PH_MAGIC: begin
                    if (magic_ok_reg && magic_prog_reg == 2'd2) begin
                        phase_next = PH_WIDTH;
                    end else begin
                        res_word0  = make_word(KIND_BAD_MAGIC, '0, 1'b0);
                        res_count  = 2'd1;
                        phase_next = PH_DONE;
                    end
                end
                PH_WIDTH: begin
                    width_next = acc_reg;
                    res_word0  = make_word(KIND_WIDTH, acc_reg, 1'b0);
                    res_count  = 2'd1;
                    phase_next = PH_HEIGHT;
                end
                PH_HEIGHT: begin
                    remain_next = area_sat;
                    res_word0   = make_word(KIND_HEIGHT, acc_reg, 1'b0);
                    res_count   = 2'd1;
                    phase_next  = PH_MAXVAL;
                end
                PH_MAXVAL: begin
                    res_word0 = make_word(KIND_MAXVAL,
                                          cfg.binarize_enable ? VALUE_BITS'(1) : acc_reg,
                                          1'b0);
                    res_count = 2'd1;
                    if (remain_reg == '0) begin
                        res_word1  = make_word(KIND_EMPTY, '0, 1'b0);
                        res_count  = 2'd2;
                        phase_next = PH_DONE;
                    end else begin
                        phase_next = PH_PIXELS;
                    end
                end
                PH_PIXELS: begin
                    remain_next = remain_dec;
                    res_word0   = make_word(KIND_PIXEL, pixel_val, remain_dec == '0);
                    res_count   = 2'd1;
                    if (remain_dec == '0) begin
                        phase_next = PH_DONE;
                    end
                end
                default: ;
            endcase
        end

        if (in_valid && in_eos) begin
            // Close the file: report a missing magic or a short image, then rearm.
            if (phase_reg != PH_DONE && phase_next != PH_DONE) begin
                if (res_count == 2'd0) begin
                    res_word0 = make_word((phase_next == PH_MAGIC) ? KIND_BAD_MAGIC
                                                                   : KIND_EARLY_END,
                                          '0, 1'b0);
                end else begin
                    res_word1 = make_word((phase_next == PH_MAGIC) ? KIND_BAD_MAGIC
                                                                   : KIND_EARLY_END,
                                          '0, 1'b0);
                end
                res_count = res_count + 2'd1;
            end
            phase_next      = PH_MAGIC;
            comment_next    = 1'b0;
            token_next      = 1'b0;
            digits_ok_next  = 1'b0;
            acc_next        = '0;
            magic_prog_next = 2'd0;
            magic_ok_next   = 1'b0;
            width_next      = '0;
            remain_next     = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_MAGIC;
            comment_reg    <= 1'b0;
            token_reg      <= 1'b0;
            digits_ok_reg  <= 1'b0;
            acc_reg        <= '0;
            magic_prog_reg <= 2'd0;
            magic_ok_reg   <= 1'b0;
            width_reg      <= '0;
            remain_reg     <= '0;
        end else begin
            phase_reg      <= phase_next;
            comment_reg    <= comment_next;
            token_reg      <= token_next;
            digits_ok_reg  <= digits_ok_next;
            acc_reg        <= acc_next;
            magic_prog_reg <= magic_prog_next;
            magic_ok_reg   <= magic_ok_next;
            width_reg      <= width_next;
            remain_reg     <= remain_next;
        end
    end

endmodule

// ----- src/pgmp_out_fifo.sv -----
`timescale 1ns / 1ps

module pgmp_out_fifo #(
    parameter int WORD_W = pgmp_pkg::VALUE_BITS_DEFAULT + pgmp_pkg::KIND_W + 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [1:0]        wr_count,
    input  logic [WORD_W-1:0] wr_word0,
    input  logic [WORD_W-1:0] wr_word1,
    input  logic              rd_en,
    output logic [WORD_W-1:0] rd_word,
    output logic              rd_valid,
    output logic              room_for_two
);
    import pgmp_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic [WORD_W-1:0] mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              pop;

    assign pop          = rd_en & rd_valid;
    assign rd_valid     = (count_reg != '0);
    assign rd_word      = mem[rd_ptr_reg];
    assign room_for_two = (count_reg <= CNT_W'(FIFO_DEPTH - 2));

    assign wr_ptr_next = wr_ptr_reg + PTR_W'(wr_count);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_reg + CNT_W'(wr_count) - CNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (wr_count != 2'd0) begin
            mem[wr_ptr_reg] <= wr_word0;
        end
        if (wr_count == 2'd2) begin
            mem[PTR_W'(wr_ptr_reg + 1'b1)] <= wr_word1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- src/ascii_pgm_stream_parser_core.sv -----
`timescale 1ns / 1ps

// Plain-text PGM (P2) parser. Characters of the file arrive one word per cycle
// on the s_ channel, with s_tlast high on a closing end-of-file word whose data
// is ignored. The block checks the P2 magic, then returns width, height and
// maximum value words, followed by one word per pixel, each decoded in the
// manner of atoi and clamped at 2^VALUE_BITS-1; the final pixel carries
// m_tlast. Bad magic, a zero-sized image and an early end of file are reported
// as words of their own kind with zero data. With binarise mode set over the
// APB port, pixels become 0 below the threshold and 1 otherwise, and the
// maximum reads as 1. Rate: one input word per cycle while s_tready is high, each
// handled in a single registered step. Results leave through a four-word queue;
// most input words produce at most one result, but the maximum value followed by
// an empty-size report, or end of file closing a token followed by an early-end
// report, produce two, and s_tready falls only while more than two words wait
// because the m_ side is stalled. Configuration registers: binarise enable at
// byte address 0, threshold at byte address 4; write them only while the stream
// is idle.
module ascii_pgm_stream_parser_core #(
    parameter int VALUE_BITS = pgmp_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Input stream.
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [7:0]                            s_tdata,   // [7:0] text_byte
    input  logic                                  s_tlast,   // end_of_stream
    // Result stream.
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [((VALUE_BITS+7)/8)*8-1:0]       m_tdata,   // value, zero padded
    output logic [pgmp_pkg::KIND_W-1:0]           m_tuser,   // [2:0] kind
    output logic                                  m_tlast,   // last_pixel
    // Configuration port.
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [pgmp_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [pgmp_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [pgmp_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                  pready
);
    import pgmp_pkg::*;

    localparam int TDATA_W = ((VALUE_BITS + 7) / 8) * 8;
    localparam int WORD_W  = VALUE_BITS + KIND_W + 1;

    pgmp_cfg_t         cfg;
    logic              accept;
    logic [1:0]        res_count;
    logic [WORD_W-1:0] res_word0;
    logic [WORD_W-1:0] res_word1;
    logic [WORD_W-1:0] head_word;
    logic              room_for_two;

    assign pready   = 1'b1;
    // A new word is taken whenever the queue can absorb the worst case of two results.
    assign s_tready = room_for_two;
    assign accept   = s_tvalid & s_tready;

    pgmp_cfg_regs u_cfg_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    pgmp_parser #(
        .VALUE_BITS (VALUE_BITS)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (accept),
        .in_byte   (s_tdata),
        .in_eos    (s_tlast),
        .cfg       (cfg),
        .res_count (res_count),
        .res_word0 (res_word0),
        .res_word1 (res_word1)
    );

    pgmp_out_fifo #(
        .WORD_W (WORD_W)
    ) u_out_fifo (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .wr_count     (res_count),
        .wr_word0     (res_word0),
        .wr_word1     (res_word1),
        .rd_en        (m_tready),
        .rd_word      (head_word),
        .rd_valid     (m_tvalid),
        .room_for_two (room_for_two)
    );

    // Queue words are {last_pixel, kind, value}.
    assign m_tdata = TDATA_W'(head_word[VALUE_BITS-1:0]);
    assign m_tuser = head_word[VALUE_BITS+KIND_W-1:VALUE_BITS];
    assign m_tlast = head_word[WORD_W-1];

endmodule

// ----- src/pgmp_checker.sv -----
`timescale 1ns / 1ps

`include "ascii_pgm_stream_parser_core_defines.svh"

module pgmp_checker #(
    parameter int VALUE_BITS = pgmp_pkg::VALUE_BITS_DEFAULT
) (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [((VALUE_BITS+7)/8)*8-1:0] m_tdata,
    input logic [pgmp_pkg::KIND_W-1:0]     m_tuser,
    input logic                            m_tlast
);
    import pgmp_pkg::*;

    localparam int BUNDLE_W = ((VALUE_BITS + 7) / 8) * 8 + KIND_W + 1;

    logic                m_stall;
    logic                m_last;
    logic                m_err;
    logic [BUNDLE_W-1:0] m_bundle;

    assign m_stall  = m_tvalid && !m_tready;
    assign m_last   = m_tvalid && m_tlast;
    assign m_err    = m_tvalid && (m_tuser == KIND_BAD_MAGIC || m_tuser == KIND_EARLY_END
                                   || m_tuser == KIND_EMPTY);
    assign m_bundle = {m_tlast, m_tuser, m_tdata};

    // A stalled result word keeps its contents.
    `PGMP_ASSERT_NEXT(a_m_hold, m_stall, m_tvalid && $stable(m_bundle), "stalled result changed")

    // Only a pixel word may close an image.
    `PGMP_ASSERT_NOW(a_last_is_pixel, m_last, m_tuser == KIND_PIXEL, "tlast on a non-pixel word")

    // Error reports carry no number.
    `PGMP_ASSERT_NOW(a_err_zero, m_err, m_tdata == '0, "error word with non-zero data")

    // Input back-pressure only arises from queued results.
    `PGMP_ASSERT_NOW(a_ready_cause, !s_tready, m_tvalid, "input stalled with no result waiting")

endmodule

bind ascii_pgm_stream_parser_core pgmp_checker #(
    .VALUE_BITS (VALUE_BITS)
) u_pgmp_checker (.*);

// ----- bench/ascii_pgm_stream_parser_core_test.sv -----
`timescale 1ns / 1ps

module ascii_pgm_stream_parser_core_test;
    import pgmp_pkg::*;

    localparam int VW = VALUE_BITS_DEFAULT;
    localparam int DW = ((VW + 7) / 8) * 8;
    localparam longint unsigned VALUE_MAX = (64'd1 << VW) - 1;
    localparam logic [VW-1:0] VALUE_ONE = VW'(1);
    localparam int PHASE_COUNT = 5;
    localparam int WORDS_PER_PHASE = 300;
    localparam int HOLD_OFF_CYCLES = 300;

    // One character word of the input stream, and one result word as the parser
    // should return it.
    typedef struct packed {
        logic [7:0] ch;
        logic       eos;
    } text_word_t;

    typedef struct packed {
        pgmp_kind_t    kind;
        logic [VW-1:0] value;
        logic          last;
    } parse_result_t;

    // A row of the directed part. Where typed is set, the result is written
    // out by hand and replaces whatever the predictor produces for that row.
    typedef struct packed {
        text_word_t    w;
        logic          typed;
        parse_result_t want;
    } directed_row_t;

    logic          aclk;
    logic          aresetn  = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [7:0]    s_tdata  = '0;
    logic          s_tlast  = 1'b0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [DW-1:0] m_tdata;
    logic [KIND_W-1:0] m_tuser;
    logic          m_tlast;
    logic          psel     = 1'b0;
    logic          penable  = 1'b0;
    logic          pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr  = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic          pready;

    // Parser state as the predictor keeps it, together with its own copy of
    // the two configuration registers.
    pgmp_phase_t   parse_phase;
    logic          comment_open;
    logic          in_token;
    logic          digits_ok;
    logic          magic_match;
    logic [1:0]    magic_pos;
    logic [VW-1:0] number_acc;
    logic [VW-1:0] image_width;
    logic [31:0]   pixels_left;
    pgmp_cfg_t     model_cfg;

    parse_result_t step_results[$];      // results of the word just accepted
    parse_result_t expected_results[$];  // results still owed by the block
    text_word_t    file_words[$];        // characters of the file being sent
    directed_row_t directed_rows[$];

    int   error_count = 0;
    int   burst_left  = 0;
    int   rx_cycle    = 0;
    int   stall_mode  = 0;
    int   hold_left   = 0;
    logic hold_request = 1'b0;

    logic          binarise_plan[PHASE_COUNT];
    logic [15:0]   threshold_plan[PHASE_COUNT];

    ascii_pgm_stream_parser_core #(
        .VALUE_BITS (VW)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // A hard ceiling on the run, far above what a correct block needs even
    // with every stall the bench can produce.
    initial begin
        #1_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report_mismatch(string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Predictor of the parser.
    // ------------------------------------------------------------------

    task automatic rearm_parser();
        parse_phase  = PH_MAGIC;
        comment_open = 1'b0;
        in_token     = 1'b0;
        digits_ok    = 1'b0;
        magic_match  = 1'b0;
        magic_pos    = '0;
        number_acc   = '0;
        image_width  = '0;
        pixels_left  = '0;
    endtask

    task automatic add_result(pgmp_kind_t kind, logic [VW-1:0] value, logic last);
        parse_result_t r;
        r.kind  = kind;
        r.value = value;
        r.last  = last;
        step_results.push_back(r);
    endtask

    // A token has ended: what it means depends on where in the file we are.
    task automatic close_token();
        logic [63:0]   area;
        logic [VW-1:0] pix;
        in_token = 1'b0;
        case (parse_phase)
            PH_MAGIC: begin
                if (magic_match && magic_pos == 2'd2) begin
                    parse_phase = PH_WIDTH;
                end else begin
                    add_result(KIND_BAD_MAGIC, '0, 1'b0);
                    parse_phase = PH_DONE;
                end
            end
            PH_WIDTH: begin
                image_width = number_acc;
                add_result(KIND_WIDTH, number_acc, 1'b0);
                parse_phase = PH_HEIGHT;
            end
            PH_HEIGHT: begin
                area = 64'(image_width);
                area = area * 64'(number_acc);
                pixels_left = (area > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : area[31:0];
                add_result(KIND_HEIGHT, number_acc, 1'b0);
                parse_phase = PH_MAXVAL;
            end
            PH_MAXVAL: begin
                add_result(KIND_MAXVAL, model_cfg.binarize_enable ? VALUE_ONE : number_acc,
                           1'b0);
                if (pixels_left == 0) begin
                    add_result(KIND_EMPTY, '0, 1'b0);
                    parse_phase = PH_DONE;
                end else begin
                    parse_phase = PH_PIXELS;
                end
            end
            PH_PIXELS: begin
                pix = number_acc;
                if (model_cfg.binarize_enable) begin
                    pix = (number_acc < model_cfg.threshold) ? '0 : VALUE_ONE;
                end
                pixels_left = pixels_left - 32'd1;
                add_result(KIND_PIXEL, pix, pixels_left == 0);
                if (pixels_left == 0) begin
                    parse_phase = PH_DONE;
                end
            end
            default: begin
            end
        endcase
    endtask

    // Works out the results of one accepted word into step_results.
    task automatic parse_word(logic [7:0] c, logic eos);
        logic [63:0] wide;
        step_results.delete();
        if (eos) begin
            if (parse_phase != PH_DONE) begin
                if (in_token) begin
                    close_token();
                end
                if (parse_phase == PH_MAGIC) begin
                    add_result(KIND_BAD_MAGIC, '0, 1'b0);
                end else if (parse_phase != PH_DONE) begin
                    add_result(KIND_EARLY_END, '0, 1'b0);
                end
            end
            rearm_parser();
        end else if (parse_phase != PH_DONE) begin
            if (comment_open) begin
                if (c == CHAR_LF) begin
                    comment_open = 1'b0;
                end
            end else if (c == CHAR_HASH) begin
                if (in_token) begin
                    close_token();
                end
                comment_open = 1'b1;
            end else if (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_LF) begin
                if (in_token) begin
                    close_token();
                end
            end else begin
                if (!in_token) begin
                    in_token    = 1'b1;
                    digits_ok   = 1'b1;
                    number_acc  = '0;
                    magic_pos   = '0;
                    magic_match = 1'b1;
                end
                if (digits_ok) begin
                    if (c >= CHAR_0 && c <= CHAR_9) begin
                        wide = 64'(number_acc);
                        wide = wide * 64'd10 + 64'(c - CHAR_0);
                        number_acc = (wide > VALUE_MAX) ? {VW{1'b1}} : wide[VW-1:0];
                    end else begin
                        digits_ok = 1'b0;
                    end
                end
                if (magic_match) begin
                    if (magic_pos == 2'd0 && c == CHAR_P) begin
                        magic_pos = 2'd1;
                    end else if (magic_pos == 2'd1 && c == CHAR_2) begin
                        magic_pos = 2'd2;
                    end else begin
                        magic_match = 1'b0;
                    end
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Driving the input stream and the register port.
    // ------------------------------------------------------------------

    // Offers one word, in bursts of random length separated by random gaps,
    // and predicts its results once the block has taken it. Valid is left
    // high afterwards so that back-to-back words need no extra assignment.
    task automatic send_word(text_word_t w, logic typed, parse_result_t want);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= w.ch;
        s_tlast  <= w.eos;
        do @(posedge aclk); while (!s_tready);
        parse_word(w.ch, w.eos);
        if (typed) begin
            expected_results.push_back(want);
        end else begin
            foreach (step_results[i]) expected_results.push_back(step_results[i]);
        end
    endtask

    // Setup phase, then access phase; the register takes the value on the
    // edge that closes the access. The bus then idles before the next
    // transfer may start.
    task automatic write_register(logic idx, logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_BINARIZE) begin
            model_cfg.binarize_enable = data[0];
        end else begin
            model_cfg.threshold = data[THRESH_W-1:0];
        end
        @(posedge aclk);
    endtask

    // Stops offering words and waits for every owed result, then waits on before
    // its final check, since a word that yields nothing may still be in flight.
    task automatic wait_until_idle();
        int waited;
        s_tvalid  <= 1'b0;
        burst_left = 0;
        waited     = 0;
        while (expected_results.size() != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (10) @(posedge aclk);
        if (expected_results.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_results.size()));
            expected_results.delete();
        end
    endtask

    // ------------------------------------------------------------------
    // Building files for the random part.
    // ------------------------------------------------------------------

    task automatic push_word(logic [7:0] ch, logic eos);
        text_word_t w;
        w.ch  = ch;
        w.eos = eos;
        file_words.push_back(w);
    endtask

    // Any character that belongs inside a token, optionally excluding digits.
    function automatic logic [7:0] token_char(logic allow_digit);
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_LF || c == CHAR_HASH
               || (!allow_digit && c >= CHAR_0 && c <= CHAR_9));
        return c;
    endfunction

    task automatic queue_number(longint unsigned v);
        logic [7:0]      digits[$];
        longint unsigned rest;
        rest = v;
        do begin
            digits.push_front(CHAR_0 + 8'(rest % 10));
            rest = rest / 10;
        end while (rest != 0);
        if ($urandom_range(0, 7) == 0) begin
            digits.push_front(CHAR_0);
        end
        foreach (digits[i]) push_word(digits[i], 1'b0);
    endtask

    // A number token, now and then in a misshapen form: far too many digits,
    // a non-digit start, or junk after the digits.
    task automatic queue_token(longint unsigned v);
        case ($urandom_range(0, 9))
            0: repeat ($urandom_range(6, 12)) push_word(CHAR_0 + 8'($urandom_range(1, 9)), 1'b0);
            1: begin
                push_word(token_char(1'b0), 1'b0);
                repeat ($urandom_range(0, 3)) push_word(token_char(1'b1), 1'b0);
            end
            2: begin
                queue_number(v);
                push_word(token_char(1'b0), 1'b0);
                repeat ($urandom_range(0, 2)) push_word(token_char(1'b1), 1'b0);
            end
            default: queue_number(v);
        endcase
    endtask

    // White space between tokens, sometimes with a comment; a comment on its
    // own also ends a token.
    task automatic queue_gap();
        int         n;
        logic [7:0] c;
        n = $urandom_range(0, 2);
        repeat (n) begin
            case ($urandom_range(0, 2))
                0:       push_word(CHAR_SPACE, 1'b0);
                1:       push_word(CHAR_TAB, 1'b0);
                default: push_word(CHAR_LF, 1'b0);
            endcase
        end
        if (n == 0 || $urandom_range(0, 5) == 0) begin
            push_word(CHAR_HASH, 1'b0);
            repeat ($urandom_range(0, 6)) begin
                do c = 8'($urandom_range(0, 255)); while (c == CHAR_LF);
                push_word(c, 1'b0);
            end
            push_word(CHAR_LF, 1'b0);
        end
    endtask

    // Pixel values cluster round the threshold so that binarise mode sees
    // both sides of it.
    function automatic longint unsigned pick_pixel();
        longint unsigned thr;
        thr = model_cfg.threshold;
        case ($urandom_range(0, 5))
            0:       return thr;
            1:       return (thr == 0) ? 0 : thr - 1;
            2:       return thr + 1;
            3:       return $urandom_range(0, 65535);
            4:       return VALUE_MAX;
            default: return $urandom_range(0, 300);
        endcase
    endfunction

    // One whole file, closed by an end-of-file word. Half are well formed
    // with small images; the rest are noise, bad magic, empty sizes, huge
    // sizes cut short, files ending early, and files with trailing junk.
    task automatic queue_file();
        int unsigned     style;
        int unsigned     w;
        int unsigned     h;
        longint unsigned n_tokens;
        longint unsigned stop_at;
        longint unsigned t;
        style = $urandom_range(0, 15);
        if (style == 0) begin
            repeat ($urandom_range(1, 24)) push_word(8'($urandom_range(0, 255)), 1'b0);
            push_word(8'h00, 1'b1);
            return;
        end
        if ($urandom_range(0, 3) == 0) begin
            queue_gap();
        end
        push_word(CHAR_P, 1'b0);
        if (style == 1) begin
            case ($urandom_range(0, 3))
                0: push_word(CHAR_2 + 8'd1, 1'b0);
                1: begin
                    push_word(CHAR_2, 1'b0);
                    push_word(CHAR_2, 1'b0);
                end
                2: begin
                end
                default: begin
                    push_word(CHAR_2, 1'b0);
                    push_word(8'h0D, 1'b0);
                end
            endcase
        end else begin
            push_word(CHAR_2, 1'b0);
        end
        queue_gap();
        w = $urandom_range(1, 3);
        h = $urandom_range(1, 3);
        if (style == 2) w = 0;
        if (style == 3) h = 0;
        if (style == 4) begin
            w = $urandom_range(1000, 99999);
            h = $urandom_range(1000, 99999);
        end
        n_tokens = 3 + longint'(w) * h;
        stop_at  = n_tokens;
        if (style == 4) begin
            stop_at = 3 + $urandom_range(0, 4);
        end else if (style == 5 || style == 6) begin
            stop_at = $urandom_range(0, 32'(n_tokens - 1));
        end
        for (t = 0; t < stop_at; t++) begin
            case (t)
                0:       queue_number(w);
                1:       queue_number(h);
                2:       queue_token($urandom_range(1, 65535));
                default: queue_token(pick_pixel());
            endcase
            if (t + 1 < stop_at || $urandom_range(0, 1) == 1) begin
                queue_gap();
            end
        end
        if (style == 7) begin
            queue_gap();
            repeat ($urandom_range(1, 10)) push_word(8'($urandom_range(0, 255)), 1'b0);
        end
        push_word(8'h00, 1'b1);
    endtask

    task automatic add_row(logic [7:0] ch, logic eos);
        directed_row_t r;
        r.w.ch  = ch;
        r.w.eos = eos;
        r.typed = 1'b0;
        r.want  = '0;
        directed_rows.push_back(r);
    endtask

    task automatic add_row_expecting(logic [7:0] ch, logic eos, pgmp_kind_t kind,
                                     logic [VW-1:0] value);
        directed_row_t r;
        r.w.ch       = ch;
        r.w.eos      = eos;
        r.typed      = 1'b1;
        r.want.kind  = kind;
        r.want.value = value;
        r.want.last  = 1'b0;
        directed_rows.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Result side: a randomly chosen stall pattern that changes periodically, plus one
    // long hold-off on request so that the result queue fills and the block
    // has to push back on its input.
    // ------------------------------------------------------------------

    task automatic check_result();
        parse_result_t want;
        if (expected_results.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected: kind %0d value %0d last %0b",
                                      m_tuser, m_tdata, m_tlast));
            return;
        end
        want = expected_results.pop_front();
        if (m_tuser !== want.kind)
            report_mismatch($sformatf("kind: got %0d, expected %0d", m_tuser, want.kind));
        if (m_tdata !== want.value)
            report_mismatch($sformatf("value: got %0d, expected %0d (kind %0d)",
                                      m_tdata, want.value, want.kind));
        if (m_tlast !== want.last)
            report_mismatch($sformatf("last pixel flag: got %0b, expected %0b",
                                      m_tlast, want.last));
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            check_result();
        end
        rx_cycle++;
        if (hold_request) begin
            hold_left    = HOLD_OFF_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (rx_cycle % 64 == 0) begin
                stall_mode = $urandom_range(0, 3);
            end
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= (rx_cycle % 5 != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------

    initial begin
        int phase_i;
        int sent;

        rearm_parser();
        model_cfg.binarize_enable = 1'b0;
        model_cfg.threshold       = THRESH_RESET;

        // Binarise off and on, threshold at both ends and in between.
        binarise_plan  = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0};
        threshold_plan = '{16'h0000, 16'hFFFF, 16'($urandom_range(1, 65534)), 16'h0000,
                           16'($urandom_range(0, 65535))};

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part, at the reset settings. End of file before any token
        // is a bad magic; then a file whose width is zero, with the height
        // closed by a comment marker, a comment holding an all-ones byte, and
        // a maximum value followed by an empty-size report. The digit after
        // that is ignored. Next a zero byte inside the first token spoils the
        // magic, and finally a good magic cut off by end of file is an early
        // end.
        add_row_expecting(8'h00, 1'b1, KIND_BAD_MAGIC, '0);
        add_row(CHAR_P, 1'b0);
        add_row(CHAR_2, 1'b0);
        add_row(CHAR_SPACE, 1'b0);
        add_row(CHAR_0, 1'b0);
        add_row_expecting(CHAR_TAB, 1'b0, KIND_WIDTH, '0);
        add_row(CHAR_9, 1'b0);
        add_row_expecting(CHAR_HASH, 1'b0, KIND_HEIGHT, 9);
        add_row(8'hFF, 1'b0);
        add_row(CHAR_LF, 1'b0);
        add_row(CHAR_0 + 8'd7, 1'b0);
        add_row(CHAR_LF, 1'b0);
        add_row(CHAR_0 + 8'd5, 1'b0);
        add_row(8'h00, 1'b1);
        add_row(8'h00, 1'b0);
        add_row_expecting(CHAR_SPACE, 1'b0, KIND_BAD_MAGIC, '0);
        add_row(8'hFF, 1'b1);
        add_row(CHAR_P, 1'b0);
        add_row(CHAR_2, 1'b0);
        add_row_expecting(8'h00, 1'b1, KIND_EARLY_END, '0);

        foreach (directed_rows[i]) begin
            send_word(directed_rows[i].w, directed_rows[i].typed, directed_rows[i].want);
        end
        wait_until_idle();

        // Random part: one batch of files per register setting.
        for (phase_i = 0; phase_i < PHASE_COUNT; phase_i++) begin
            write_register(REG_BINARIZE, {31'd0, binarise_plan[phase_i]});
            write_register(REG_THRESHOLD, {16'd0, threshold_plan[phase_i]});
            if (phase_i == 0) begin
                hold_request = 1'b1;
            end
            sent = 0;
            while (sent < WORDS_PER_PHASE) begin
                queue_file();
                sent += file_words.size();
                while (file_words.size() != 0) begin
                    send_word(file_words.pop_front(), 1'b0, '0);
                end
            end
            wait_until_idle();
        end

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
